// File: rtl/wsop_pkg.sv
// Shared types, constants and tables for the waypoint steering block.
package wsop_pkg;

  localparam int unsigned NumWatched = 13;
  localparam int unsigned NumLeft    = 7;
  localparam int unsigned MaxSteps   = 24;

  localparam logic [2:0] RegCruise    = 3'd0;
  localparam logic [2:0] RegRadius    = 3'd1;
  localparam logic [2:0] RegThreshold = 3'd2;
  localparam logic [2:0] RegOffset    = 3'd3;
  localparam logic [2:0] RegGain      = 3'd4;

  localparam logic [15:0] ResetCruise    = 16'd307;
  localparam logic [15:0] ResetRadius    = 16'd1024;
  localparam logic [15:0] ResetThreshold = 16'd1024;
  localparam logic [15:0] ResetOffset    = 16'd2048;
  localparam logic [9:0]  ResetGain      = 10'd128;

  // Q10 radians per binary-angle unit, times 2^16
  localparam logic [12:0] RadScale = 13'd6434;

  // controller -> datapath
  typedef struct packed {
    logic load;    // capture pose and start
    logic prep;    // form squared distance and quadrant fold
    logic step;    // one CORDIC iteration
    logic angle;   // heading error
    logic scale;   // magnitude to radians
    logic sum;     // accumulate one beam slot
    logic push;    // gain multiply
    logic finish;  // combine and saturate
  } wsop_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic steps_done;
    logic sum_done;
  } wsop_sts_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

  // beam number to watched slot; valid flag in bit 4
  function automatic logic [4:0] slot_of(input logic [8:0] beam);
    logic [4:0] r;
    unique case (beam)
      9'd180: r = {1'b1, 4'd0};
      9'd210: r = {1'b1, 4'd1};
      9'd240: r = {1'b1, 4'd2};
      9'd270: r = {1'b1, 4'd3};
      9'd300: r = {1'b1, 4'd4};
      9'd330: r = {1'b1, 4'd5};
      9'd360: r = {1'b1, 4'd6};
      9'd175: r = {1'b1, 4'd7};
      9'd145: r = {1'b1, 4'd8};
      9'd115: r = {1'b1, 4'd9};
      9'd85:  r = {1'b1, 4'd10};
      9'd55:  r = {1'b1, 4'd11};
      9'd25:  r = {1'b1, 4'd12};
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/wsop_ctrl.sv
// Sequencer for one pose beat: arrival test, CORDIC, beam sum, combine.
module wsop_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                out_free_i,
  input  wsop_pkg::wsop_sts_t sts_i,
  output wsop_pkg::wsop_cmd_t cmd_o,
  output logic                busy_o,
  output logic                done_o
);
  import wsop_pkg::*;

  typedef enum logic [3:0] {
    StIdle, StPrep, StCordic, StAngle, StScale, StSum, StPush, StFinish, StWait
  } state_e;

  state_e state_q;

  always_comb begin
    cmd_o        = '0;
    cmd_o.load   = start_i && state_q == StIdle;
    cmd_o.prep   = state_q == StPrep;
    cmd_o.step   = state_q == StCordic;
    cmd_o.angle  = state_q == StAngle;
    cmd_o.scale  = state_q == StScale;
    cmd_o.sum    = state_q == StSum;
    cmd_o.push   = state_q == StPush;
    cmd_o.finish = state_q == StWait && out_free_i;
  end

  assign busy_o = state_q != StIdle;
  assign done_o = cmd_o.finish;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      unique case (state_q)
        StIdle:   if (start_i) state_q <= StPrep;
        StPrep:   state_q <= StCordic;
        StCordic: if (sts_i.steps_done) state_q <= StAngle;
        StAngle:  state_q <= StScale;
        StScale:  state_q <= StSum;
        StSum:    if (sts_i.sum_done) state_q <= StPush;
        StPush:   state_q <= StFinish;
        StFinish: state_q <= StWait;
        StWait:   if (out_free_i) state_q <= StIdle;
        default:  state_q <= StIdle;
      endcase
    end
  end
endmodule

// File: rtl/wsop_dp.sv
// Datapath: beam store, CORDIC unit, obstacle sum and turn combine.
module wsop_dp #(
  parameter int unsigned CordicSteps = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wsop_pkg::wsop_cmd_t cmd_i,
  output wsop_pkg::wsop_sts_t sts_o,
  input  logic                beam_we_i,
  input  logic [8:0]          beam_index_i,
  input  logic [15:0]         beam_range_i,
  input  logic signed [15:0]  pos_x_i,
  input  logic signed [15:0]  pos_y_i,
  input  logic [15:0]         heading_i,
  input  logic signed [15:0]  target_x_i,
  input  logic signed [15:0]  target_y_i,
  input  logic [15:0]         radius_i,
  input  logic [15:0]         threshold_i,
  input  logic [15:0]         offset_i,
  input  logic [9:0]          gain_i,
  output logic signed [15:0]  turn_o,
  output logic                arrived_o
);
  import wsop_pkg::*;

  localparam int unsigned Steps = (CordicSteps < MaxSteps) ? CordicSteps : MaxSteps;

  logic [15:0] ranges_q [NumWatched];
  logic [4:0]  slot;

  assign slot = slot_of(beam_index_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumWatched; k++) ranges_q[k] <= '1;
    end else if (beam_we_i && slot[4]) begin
      ranges_q[slot[3:0]] <= beam_range_i;
    end
  end

  // operands: |dx|,|dy| < 2^16, scaled by 256 and grown by CORDIC gain
  logic signed [16:0] dx_q, dy_q;
  logic [15:0]        head_q;
  logic [33:0]        d2_q;
  logic               arr_q, zero_q;
  logic signed [27:0] cx_q, cy_q;
  logic [31:0]        ang_q;
  logic [4:0]         it_q;
  logic [15:0]        mag_q;
  logic               neg_q;
  logic signed [16:0] base_q;
  logic [3:0]         k_q;
  logic signed [20:0] field_q;
  logic signed [31:0] prod_q;

  logic [33:0]        dx2, dy2;
  logic [31:0]        r2;
  logic signed [27:0] xs, ys;
  logic [31:0]        err32, errr;
  logic signed [15:0] err;
  logic [15:0]        emag;
  logic [29:0]        scaled;
  logic [15:0]        rng;
  logic signed [17:0] term;
  logic signed [31:0] pr;
  logic signed [23:0] push;
  logic signed [24:0] tsum;

  assign dx2    = unsigned'(34'(dx_q) * 34'(dx_q));
  assign dy2    = unsigned'(34'(dy_q) * 34'(dy_q));
  assign r2     = 32'(radius_i) * 32'(radius_i);
  assign xs     = cx_q >>> it_q;
  assign ys     = cy_q >>> it_q;
  assign err32  = ang_q - {head_q, 16'h0};
  assign errr   = err32 + 32'h8000;
  assign err    = signed'(errr[31:16]);
  assign emag   = err[15] ? 16'(-err) : 16'(err);
  assign scaled = 30'(mag_q) * 30'(RadScale) + 30'd32768;
  assign rng    = ranges_q[k_q];
  assign term   = signed'(18'(offset_i)) - signed'(18'(rng));
  assign pr     = signed'(32'(gain_i)) * 32'(field_q) + 32'sd128;
  assign push   = 24'(prod_q >>> 8);
  assign tsum   = 25'(base_q) - 25'(push);

  assign sts_o.steps_done = it_q == 5'(Steps - 1);
  assign sts_o.sum_done   = k_q == 4'(NumWatched - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arrived_o <= 1'b0;
      turn_o    <= '0;
    end else begin
      if (cmd_i.load) begin
        dx_q   <= 17'(target_x_i) - 17'(pos_x_i);
        dy_q   <= 17'(target_y_i) - 17'(pos_y_i);
        head_q <= heading_i;
      end
      if (cmd_i.prep) begin
        d2_q   <= dx2 + dy2;
        zero_q <= dx_q == '0 && dy_q == '0;
        it_q   <= '0;
        if (dx_q < 0) begin
          cx_q  <= -(28'(dx_q) <<< 8);
          cy_q  <= -(28'(dy_q) <<< 8);
          ang_q <= 32'h80000000;
        end else begin
          cx_q  <= 28'(dx_q) <<< 8;
          cy_q  <= 28'(dy_q) <<< 8;
          ang_q <= '0;
        end
      end
      if (cmd_i.step) begin
        it_q <= it_q + 5'd1;
        if (cy_q > 0) begin
          cx_q  <= cx_q + ys;
          cy_q  <= cy_q - xs;
          ang_q <= ang_q + atan_turn(it_q);
        end else begin
          cx_q  <= cx_q - ys;
          cy_q  <= cy_q + xs;
          ang_q <= ang_q - atan_turn(it_q);
        end
      end
      if (cmd_i.angle) begin
        arr_q <= d2_q < 34'(r2);
        neg_q <= err[15] && err != -16'sd32768;
        mag_q <= (emag > 16'd16384) ? 16'd16384 : emag;
        k_q   <= '0;
        field_q <= '0;
      end
      if (cmd_i.scale) begin
        base_q <= zero_q ? 17'sd0
                : (neg_q ? -17'(scaled[29:16]) : 17'(scaled[29:16]));
      end
      if (cmd_i.sum) begin
        k_q <= k_q + 4'd1;
        if (rng < threshold_i) begin
          field_q <= (k_q < 4'(NumLeft)) ? field_q + 21'(term) : field_q - 21'(term);
        end
      end
      if (cmd_i.push) prod_q <= pr;
      if (cmd_i.finish) begin
        arrived_o <= arr_q;
        if (arr_q)                    turn_o <= '0;
        else if (tsum > 25'sd32767)   turn_o <= 16'sh7FFF;
        else if (tsum < -25'sd32768)  turn_o <= -16'sd32768;
        else                          turn_o <= 16'(tsum);
      end
    end
  end
endmodule

// File: rtl/waypoint_steering_with_obstacle_push.sv
// Top level of the waypoint steering controller with obstacle push.
//
// Input channel (in_valid_i/in_stall_o): operation 0 beats store a range
// for one of 13 watched beams and produce no result.
// Operation 1 beats take the pose and target and produce one command on
// the output channel (out_valid_o/out_stall_i).
// A pose beat runs through these steps before out_valid_o: prepare,
// CORDIC_STEPS iterations (capped at MaxSteps) of the vectoring unit,
// angle and scaling, the beam sum one slot per cycle, gain multiply,
// combine. The result register is loaded while the output is free;
// the next beat is taken as soon as the sequencer returns to idle,
// which happens on the same clock edge that loads the result.
// A stalled receiver holds the result and the sequencer waits.
// Reset sets the configuration registers to their defaults and all
// watched ranges to all ones (no obstacle).
module waypoint_steering_with_obstacle_push #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               operation_i,
  input  logic [8:0]         beam_index_i,
  input  logic [15:0]        beam_range_i,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic [15:0]        heading_i,
  input  logic signed [15:0] target_x_i,
  input  logic signed [15:0] target_y_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [15:0]        forward_speed_o,
  output logic signed [15:0] turn_rate_o,
  output logic               arrived_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);
  import wsop_pkg::*;

  logic [15:0] cruise_q, radius_q, threshold_q, offset_q;
  logic [9:0]  gain_q;
  logic        busy, done, in_acc, out_free;
  wsop_cmd_t   cmd;
  wsop_sts_t   sts;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = busy;
  assign in_acc      = in_valid_i && !busy;
  assign out_free    = !out_valid_o || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cruise_q    <= ResetCruise;
      radius_q    <= ResetRadius;
      threshold_q <= ResetThreshold;
      offset_q    <= ResetOffset;
      gain_q      <= ResetGain;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegCruise:    cruise_q    <= cfg_data_i;
        RegRadius:    radius_q    <= cfg_data_i;
        RegThreshold: threshold_q <= cfg_data_i;
        RegOffset:    offset_q    <= cfg_data_i;
        RegGain:      gain_q      <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o     <= 1'b0;
      forward_speed_o <= '0;
    end else if (done) begin
      out_valid_o     <= 1'b1;
      forward_speed_o <= cruise_q;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  wsop_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_acc && operation_i),
    .out_free_i (out_free),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .busy_o     (busy),
    .done_o     (done)
  );

  wsop_dp #(.CordicSteps(CORDIC_STEPS)) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .beam_we_i    (in_acc && !operation_i),
    .beam_index_i (beam_index_i),
    .beam_range_i (beam_range_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .heading_i    (heading_i),
    .target_x_i   (target_x_i),
    .target_y_i   (target_y_i),
    .radius_i     (radius_q),
    .threshold_i  (threshold_q),
    .offset_i     (offset_q),
    .gain_i       (gain_q),
    .turn_o       (turn_rate_o),
    .arrived_o    (arrived_o)
  );
endmodule
